/* rtl/dmf_pkg.sv */
// Package: shared constants and controller state types for the max-flow unit.
`timescale 1ns / 1ps
package dmf_pkg;
    localparam int DEF_MAX_NODES = 256;
    localparam int DEF_MAX_EDGES = 1024;
    localparam int DEF_CAP_BITS  = 16;
    localparam int NODE_W        = 9;
    localparam int CAP_IN_W      = 16;
    localparam int FLOW_W        = 26;
    localparam int SOURCE_NODE   = 1;

    typedef enum logic [4:0] {
        S_IDLE, S_L0, S_L1, S_L2, S_L3, S_START,
        S_BCLR, S_BINIT, S_BPOP, S_BPOP2, S_BLEV, S_BARC, S_BARC2, S_BARC3,
        S_DCP0, S_DCP1, S_DNODE, S_DNODE2, S_DSCAN, S_DS2, S_DS3,
        S_DFAIL, S_DF2, S_DF3,
        S_AM0, S_AM1, S_AM2, S_AU0, S_AU1, S_AU2, S_AU3,
        S_OUT
    } dmf_state_t;

    // P_CLR: first-arc table is being cleared
    typedef enum logic {P_RUN, P_CLR} dmf_phase_t;
endpackage

/* rtl/dmf_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module dmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/dinic_max_flow_unit.sv */
// Top level: Dinic maximum-flow engine over RAM-held forward-star graph tables.
//
//  channel  | handshake            | words
//  ---------+----------------------+-------------------------------------------
//  cfg      | cfg_we               | cfg_wdata = node count (sink node)
//  in       | in_valid / in_stall  | tail_node, head_node, edge_capacity, last_edge
//  out      | out_valid / out_stall| max_flow, edge_overflow
//
// An edge word is accepted in S_IDLE, then S_L0 to S_L3 read and update first-arc
// for the forward and the reverse arc and write the arc pair. After the last edge
// the solver runs for a data-dependent time: each level pass sweeps the level RAM,
// then dequeues nodes and visits their arcs; each blocking pass copies first-arc
// to cursor RAM and scans arcs; every augment does a min-scan over the path arcs
// and then an update per path arc.
// After reset and after each result a clearing pass over all MAX_NODES+1 entries
// empties the first-arc RAM; no edge is taken meanwhile. A stalled result holds in the
// output register while the clearing pass and the next edge words proceed.
`timescale 1ns / 1ps
module dinic_max_flow_unit
    import dmf_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES,
    parameter int CAP_BITS  = DEF_CAP_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [NODE_W-1:0]   cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [NODE_W-1:0]   tail_node,
    input  logic [NODE_W-1:0]   head_node,
    input  logic [CAP_IN_W-1:0] edge_capacity,
    input  logic                last_edge,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [FLOW_W-1:0]   max_flow,
    output logic                edge_overflow
);
    localparam int ARC_SLOTS = 2 * MAX_EDGES + 2;
    localparam int NDEPTH    = MAX_NODES + 1;
    localparam int AW        = $clog2(ARC_SLOTS);
    localparam int NW        = $clog2(NDEPTH);
    localparam int QW        = $clog2(MAX_NODES + 2);
    localparam int LW        = NW + 1;
    localparam logic [NW-1:0] CMAX = NW'(MAX_NODES);
    localparam logic [NW-1:0] SRC  = NW'(SOURCE_NODE);

    dmf_state_t state_reg, state_next;
    dmf_phase_t phase_reg, phase_next;   // P_CLR: clearing pass in progress

    logic [AW-1:0]       arc_cnt_reg, arc_cnt_next;
    logic [FLOW_W-1:0]   flow_reg, flow_next;
    logic                ovf_reg, ovf_next;
    logic [NODE_W-1:0]   ncount_reg;
    logic [NW-1:0]       cnt_reg, cnt_next;
    logic [QW-1:0]       qh_reg, qh_next, qt_reg, qt_next;
    logic [QW-1:0]       depth_reg, depth_next, i_reg, i_next;
    logic                outv_reg, outv_next;
    logic [FLOW_W-1:0]   oflow_reg, oflow_next;
    logic                oovf_reg, oovf_next;
    logic [NW-1:0]       tail_reg, tail_next, head_reg, head_next;
    logic [CAP_BITS-1:0] cap_reg, cap_next;
    logic                last_reg, last_next;
    logic [NW-1:0]       u_reg, u_next, v_reg, v_next;
    logic [LW-1:0]       ulev_reg, ulev_next;
    logic [AW-1:0]       a_reg, a_next, nxt_reg, nxt_next;
    logic [CAP_BITS-1:0] res_reg, res_next, b_reg, b_next;

    // RAM ports
    logic                arc_we, res_we;
    logic [AW-1:0]       arc_wa, res_wa, arc_ra;
    logic [NW-1:0]       tgt_wd, tgt_rd;
    logic [CAP_BITS-1:0] res_wd, res_rd;
    logic [AW-1:0]       nxt_wd, nxt_rd;
    logic                fst_we, cur_we, lev_we, que_we, stk_we;
    logic [NW-1:0]       fst_wa, cur_wa, lev_wa, que_wa, stk_wa;
    logic [NW-1:0]       fst_ra, cur_ra, lev_ra, que_ra, stk_ra;
    logic [AW-1:0]       fst_wd, fst_rd, cur_wd, cur_rd, stk_wd, stk_rd;
    logic [LW-1:0]       lev_wd, lev_rd;
    logic [NW-1:0]       que_wd, que_rd;

    dmf_ram #(.WIDTH(NW), .DEPTH(ARC_SLOTS)) u_tgt (.clk(clk), .we(arc_we),
        .waddr(arc_wa), .wdata(tgt_wd), .raddr(arc_ra), .rdata(tgt_rd));
    dmf_ram #(.WIDTH(AW), .DEPTH(ARC_SLOTS)) u_nxt (.clk(clk), .we(arc_we),
        .waddr(arc_wa), .wdata(nxt_wd), .raddr(arc_ra), .rdata(nxt_rd));
    dmf_ram #(.WIDTH(CAP_BITS), .DEPTH(ARC_SLOTS)) u_res (.clk(clk), .we(res_we),
        .waddr(res_wa), .wdata(res_wd), .raddr(arc_ra), .rdata(res_rd));
    dmf_ram #(.WIDTH(AW), .DEPTH(NDEPTH)) u_fst (.clk(clk), .we(fst_we),
        .waddr(fst_wa), .wdata(fst_wd), .raddr(fst_ra), .rdata(fst_rd));
    dmf_ram #(.WIDTH(AW), .DEPTH(NDEPTH)) u_cur (.clk(clk), .we(cur_we),
        .waddr(cur_wa), .wdata(cur_wd), .raddr(cur_ra), .rdata(cur_rd));
    dmf_ram #(.WIDTH(LW), .DEPTH(NDEPTH)) u_lev (.clk(clk), .we(lev_we),
        .waddr(lev_wa), .wdata(lev_wd), .raddr(lev_ra), .rdata(lev_rd));
    dmf_ram #(.WIDTH(NW), .DEPTH(NDEPTH)) u_que (.clk(clk), .we(que_we),
        .waddr(que_wa), .wdata(que_wd), .raddr(que_ra), .rdata(que_rd));
    dmf_ram #(.WIDTH(AW), .DEPTH(NDEPTH)) u_stk (.clk(clk), .we(stk_we),
        .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));

    logic          node_ok, room, bfs_new, dfs_hit, in_take;
    logic [NW-1:0] sink;
    logic [LW-1:0] ulev1;

    assign in_take = (phase_reg == P_RUN) && (state_reg == S_IDLE) && in_valid;
    assign node_ok = (tail_node != '0) && (int'(tail_node) <= MAX_NODES)
                  && (head_node != '0) && (int'(head_node) <= MAX_NODES);
    assign room    = (int'(arc_cnt_reg) + 2) < ARC_SLOTS;
    assign sink    = (int'(ncount_reg) > MAX_NODES) ? CMAX : NW'(ncount_reg);
    assign ulev1   = LW'(ulev_reg + 1'b1);
    assign bfs_new = (res_reg != '0) && (lev_rd == '0);
    assign dfs_hit = (res_reg != '0) && (lev_rd == ulev1);

    assign in_stall      = !((phase_reg == P_RUN) && (state_reg == S_IDLE));
    assign out_valid     = outv_reg;
    assign max_flow      = oflow_reg;
    assign edge_overflow = oovf_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        if (phase_reg == P_CLR)
        begin
            if (cnt_reg == CMAX)
            begin
                phase_next = P_RUN;
                state_next = S_IDLE;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (node_ok && room)
                        begin
                            state_next = S_L0;
                        end
                        else if (last_edge)
                        begin
                            state_next = S_START;
                        end
                    end
                end
                S_L0:     state_next = S_L1;
                S_L1:     state_next = S_L2;
                S_L2:     state_next = S_L3;
                S_L3:     state_next = last_reg ? S_START : S_IDLE;
                S_START:  state_next = (sink > SRC) ? S_BCLR : S_OUT;
                S_BCLR:   state_next = (cnt_reg == CMAX) ? S_BINIT : S_BCLR;
                S_BINIT:  state_next = S_BPOP;
                S_BPOP:   state_next = (qh_reg < qt_reg) ? S_BPOP2 : S_OUT;
                S_BPOP2:  state_next = S_BLEV;
                S_BLEV:   state_next = S_BARC;
                S_BARC:   state_next = (a_reg == '0) ? S_BPOP : S_BARC2;
                S_BARC2:  state_next = S_BARC3;
                S_BARC3:  state_next = (bfs_new && v_reg == sink) ? S_DCP0 : S_BARC;
                S_DCP0:   state_next = S_DCP1;
                S_DCP1:   state_next = (cnt_reg == CMAX) ? S_DNODE : S_DCP0;
                S_DNODE:  state_next = (u_reg == sink) ? S_AM0 : S_DNODE2;
                S_DNODE2: state_next = S_DSCAN;
                S_DSCAN:  state_next = (a_reg == '0) ? S_DFAIL : S_DS2;
                S_DS2:    state_next = S_DS3;
                S_DS3:    state_next = dfs_hit ? S_DNODE : S_DSCAN;
                S_DFAIL:  state_next = (depth_reg == '0) ? S_BCLR : S_DF2;
                S_DF2:    state_next = S_DF3;
                S_DF3:    state_next = S_DNODE;
                S_AM0:    state_next = (i_reg < depth_reg) ? S_AM1 : S_AU0;
                S_AM1:    state_next = S_AM2;
                S_AM2:    state_next = S_AM0;
                S_AU0:    state_next = (i_reg < depth_reg) ? S_AU1 : S_DNODE;
                S_AU1:    state_next = S_AU2;
                S_AU2:    state_next = S_AU3;
                S_AU3:    state_next = S_AU0;
                S_OUT:
                begin
                    if (!outv_reg)
                    begin
                        phase_next = P_CLR;
                    end
                end
                default:  state_next = S_IDLE;
            endcase
        end
    end

    // datapath and RAM control
    always_comb
    begin
        arc_cnt_next = arc_cnt_reg;
        flow_next    = flow_reg;
        ovf_next     = ovf_reg;
        cnt_next     = cnt_reg;
        qh_next      = qh_reg;
        qt_next      = qt_reg;
        depth_next   = depth_reg;
        i_next       = i_reg;
        outv_next    = outv_reg;
        oflow_next   = oflow_reg;
        oovf_next    = oovf_reg;
        tail_next    = tail_reg;
        head_next    = head_reg;
        cap_next     = cap_reg;
        last_next    = last_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        ulev_next    = ulev_reg;
        a_next       = a_reg;
        nxt_next     = nxt_reg;
        res_next     = res_reg;
        b_next       = b_reg;
        arc_we = 1'b0;  arc_wa = '0;  tgt_wd = '0;  nxt_wd = '0;  arc_ra = '0;
        res_we = 1'b0;  res_wa = '0;  res_wd = '0;
        fst_we = 1'b0;  fst_wa = '0;  fst_wd = '0;  fst_ra = '0;
        cur_we = 1'b0;  cur_wa = '0;  cur_wd = '0;  cur_ra = '0;
        lev_we = 1'b0;  lev_wa = '0;  lev_wd = '0;  lev_ra = '0;
        que_we = 1'b0;  que_wa = '0;  que_wd = '0;  que_ra = '0;
        stk_we = 1'b0;  stk_wa = '0;  stk_wd = '0;  stk_ra = '0;

        if (outv_reg && !out_stall)
        begin
            outv_next = 1'b0;
        end

        if (phase_reg == P_CLR)
        begin
            fst_we   = 1'b1;
            fst_wa   = cnt_reg;
            cnt_next = NW'(cnt_reg + 1'b1);
            if (cnt_reg == CMAX)
            begin
                cnt_next     = '0;
                arc_cnt_next = AW'(1);
                flow_next    = '0;
                ovf_next     = 1'b0;
            end
        end
        else
        begin
            case (state_reg) inside
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        tail_next = NW'(tail_node);
                        head_next = NW'(head_node);
                        cap_next  = CAP_BITS'(edge_capacity);
                        last_next = last_edge;
                        if (node_ok && !room)
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                S_L0: fst_ra = tail_reg;
                S_L1:
                begin
                    arc_we = 1'b1;
                    arc_wa = AW'(arc_cnt_reg + 1'b1);
                    tgt_wd = head_reg;
                    nxt_wd = fst_rd;
                    res_we = 1'b1;
                    res_wa = AW'(arc_cnt_reg + 1'b1);
                    res_wd = cap_reg;
                    fst_we = 1'b1;
                    fst_wa = tail_reg;
                    fst_wd = AW'(arc_cnt_reg + 1'b1);
                end
                S_L2: fst_ra = head_reg;
                S_L3:
                begin
                    arc_we = 1'b1;
                    arc_wa = AW'(arc_cnt_reg + 2'd2);
                    tgt_wd = tail_reg;
                    nxt_wd = fst_rd;
                    res_we = 1'b1;
                    res_wa = AW'(arc_cnt_reg + 2'd2);
                    res_wd = '0;
                    fst_we = 1'b1;
                    fst_wa = head_reg;
                    fst_wd = AW'(arc_cnt_reg + 2'd2);
                    arc_cnt_next = AW'(arc_cnt_reg + 2'd2);
                end
                S_START: cnt_next = '0;
                S_BCLR:
                begin
                    lev_we   = 1'b1;
                    lev_wa   = cnt_reg;
                    cnt_next = (cnt_reg == CMAX) ? '0 : NW'(cnt_reg + 1'b1);
                end
                S_BINIT:
                begin
                    lev_we  = 1'b1;
                    lev_wa  = SRC;
                    lev_wd  = LW'(1);
                    que_we  = 1'b1;
                    que_wa  = '0;
                    que_wd  = SRC;
                    qh_next = '0;
                    qt_next = QW'(1);
                end
                S_BPOP:
                begin
                    que_ra = qh_reg[NW-1:0];
                    if (qh_reg < qt_reg)
                    begin
                        qh_next = QW'(qh_reg + 1'b1);
                    end
                end
                S_BPOP2:
                begin
                    u_next = que_rd;
                    lev_ra = que_rd;
                    fst_ra = que_rd;
                end
                S_BLEV:
                begin
                    ulev_next = lev_rd;
                    a_next    = fst_rd;
                end
                S_BARC, S_DSCAN: arc_ra = a_reg;
                S_BARC2, S_DS2:
                begin
                    v_next   = tgt_rd;
                    res_next = res_rd;
                    nxt_next = nxt_rd;
                    lev_ra   = tgt_rd;
                end
                S_BARC3:
                begin
                    a_next = nxt_reg;
                    if (bfs_new)
                    begin
                        lev_we  = 1'b1;
                        lev_wa  = v_reg;
                        lev_wd  = ulev1;
                        que_we  = 1'b1;
                        que_wa  = qt_reg[NW-1:0];
                        que_wd  = v_reg;
                        qt_next = QW'(qt_reg + 1'b1);
                    end
                end
                S_DCP0: fst_ra = cnt_reg;
                S_DCP1:
                begin
                    cur_we   = 1'b1;
                    cur_wa   = cnt_reg;
                    cur_wd   = fst_rd;
                    cnt_next = NW'(cnt_reg + 1'b1);
                    if (cnt_reg == CMAX)
                    begin
                        cnt_next   = '0;
                        depth_next = '0;
                        u_next     = SRC;
                    end
                end
                S_DNODE:
                begin
                    cur_ra = u_reg;
                    lev_ra = u_reg;
                    i_next = '0;
                    b_next = '1;   // any residual is at most all ones
                end
                S_DNODE2:
                begin
                    a_next    = cur_rd;
                    ulev_next = lev_rd;
                end
                S_DS3:
                begin
                    if (dfs_hit)
                    begin
                        cur_we     = 1'b1;
                        cur_wa     = u_reg;
                        cur_wd     = a_reg;
                        stk_we     = 1'b1;
                        stk_wa     = depth_reg[NW-1:0];
                        stk_wd     = a_reg;
                        depth_next = QW'(depth_reg + 1'b1);
                        u_next     = v_reg;
                    end
                    else
                    begin
                        a_next = nxt_reg;
                    end
                end
                S_DFAIL:
                begin
                    // dead end: retire node and back up one arc
                    cur_we = 1'b1;
                    cur_wa = u_reg;
                    cur_wd = a_reg;
                    lev_we = 1'b1;
                    lev_wa = u_reg;
                    lev_wd = '0;
                    stk_ra = NW'(depth_reg - 1'b1);
                    if (depth_reg == '0)
                    begin
                        cnt_next = '0;
                    end
                    else
                    begin
                        depth_next = QW'(depth_reg - 1'b1);
                    end
                end
                S_DF2: arc_ra = {stk_rd[AW-1:1], ~stk_rd[0]};
                S_DF3: u_next = tgt_rd;
                S_AM0:
                begin
                    stk_ra = i_reg[NW-1:0];
                    if (!(i_reg < depth_reg))
                    begin
                        i_next = '0;
                    end
                end
                S_AM1: arc_ra = stk_rd;
                S_AM2:
                begin
                    if (res_rd < b_reg)
                    begin
                        b_next = res_rd;
                    end
                    i_next = QW'(i_reg + 1'b1);
                end
                S_AU0:
                begin
                    stk_ra = i_reg[NW-1:0];
                    if (!(i_reg < depth_reg))
                    begin
                        flow_next  = FLOW_W'(34'(flow_reg) + 34'(b_reg));
                        depth_next = '0;
                        u_next     = SRC;
                    end
                end
                S_AU1:
                begin
                    a_next = stk_rd;
                    arc_ra = stk_rd;
                end
                S_AU2:
                begin
                    res_we = 1'b1;
                    res_wa = a_reg;
                    res_wd = CAP_BITS'(res_rd - b_reg);
                    arc_ra = {a_reg[AW-1:1], ~a_reg[0]};
                end
                S_AU3:
                begin
                    res_we = 1'b1;
                    res_wa = {a_reg[AW-1:1], ~a_reg[0]};
                    res_wd = CAP_BITS'(res_rd + b_reg);
                    i_next = QW'(i_reg + 1'b1);
                end
                S_OUT:
                begin
                    if (!outv_reg)
                    begin
                        outv_next  = 1'b1;
                        oflow_next = flow_reg;
                        oovf_next  = ovf_reg;
                        cnt_next   = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            phase_reg   <= P_CLR;
            arc_cnt_reg <= AW'(1);
            flow_reg    <= '0;
            ovf_reg     <= 1'b0;
            ncount_reg  <= NODE_W'(2);
            cnt_reg     <= '0;
            qh_reg      <= '0;
            qt_reg      <= '0;
            depth_reg   <= '0;
            i_reg       <= '0;
            outv_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            arc_cnt_reg <= arc_cnt_next;
            flow_reg    <= flow_next;
            ovf_reg     <= ovf_next;
            cnt_reg     <= cnt_next;
            qh_reg      <= qh_next;
            qt_reg      <= qt_next;
            depth_reg   <= depth_next;
            i_reg       <= i_next;
            outv_reg    <= outv_next;
            if (cfg_we)
            begin
                ncount_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        oflow_reg <= oflow_next;
        oovf_reg  <= oovf_next;
        tail_reg  <= tail_next;
        head_reg  <= head_next;
        cap_reg   <= cap_next;
        last_reg  <= last_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        ulev_reg  <= ulev_next;
        a_reg     <= a_next;
        nxt_reg   <= nxt_next;
        res_reg   <= res_next;
        b_reg     <= b_next;
    end
endmodule

/* test/dinic_max_flow_unit_tb.sv */
// Testbench: checks the max-flow unit against a built-in Dinic predictor.
`timescale 1ns / 1ps
module dinic_max_flow_unit_tb;
    import dmf_pkg::*;

    localparam int NODES     = DEF_MAX_NODES;
    localparam int ARCS      = 2 * DEF_MAX_EDGES + 2;
    localparam int FLOW_CAP  = 32'h3f3f3f3f;
    localparam int IDLE_WAIT = 800;
    localparam int DOG_LIMIT = 400000;

    typedef struct packed {
        logic [FLOW_W-1:0] flow;
        logic              ovf;
    } flow_word_t;

    class flow_scoreboard;
        int                arc_to[ARCS];
        int                arc_cap[ARCS];
        int                arc_link[ARCS];
        int                first_arc[NODES+1];
        int                cursor[NODES+1];
        int                level[NODES+1];
        int                trail[NODES+1];
        int                bfs_q[NODES+1];
        int                n_arcs;
        int                total;
        logic              dropped;
        logic [NODE_W-1:0] node_cfg;
        flow_word_t        expected_q[$];
        int                fails;

        function new();
            node_cfg = 2;
            fails = 0;
            clear_graph();
        endfunction

        function void clear_graph();
            for (int i = 0; i <= NODES; i++)
            begin
                first_arc[i] = 0;
                level[i] = 0;
            end
            n_arcs = 1;
            total = 0;
            dropped = 0;
        endfunction

        function void link(int from, int to, int cap);
            n_arcs++;
            arc_to[n_arcs] = to;
            arc_cap[n_arcs] = cap;
            arc_link[n_arcs] = first_arc[from];
            first_arc[from] = n_arcs;
        endfunction

        function bit build_levels(int sink);
            int qh, qt, u, v;
            qh = 0;
            qt = 0;
            for (int i = 0; i <= NODES; i++) level[i] = 0;
            level[SOURCE_NODE] = 1;
            bfs_q[qt++] = SOURCE_NODE;
            while (qh < qt)
            begin
                u = bfs_q[qh++];
                for (int a = first_arc[u]; a != 0; a = arc_link[a])
                begin
                    v = arc_to[a];
                    if (arc_cap[a] == 0 || level[v] != 0) continue;
                    level[v] = level[u] + 1;
                    if (qt <= NODES) bfs_q[qt++] = v;
                    if (v == sink) return 1;
                end
            end
            return 0;
        endfunction

        function void push_blocking(int sink);
            int depth, u, a, b;
            depth = 0;
            u = SOURCE_NODE;
            for (int i = 0; i <= NODES; i++) cursor[i] = first_arc[i];
            forever
            begin
                if (u == sink)
                begin
                    b = FLOW_CAP;
                    for (int i = 0; i < depth; i++)
                        if (arc_cap[trail[i]] < b) b = arc_cap[trail[i]];
                    for (int i = 0; i < depth; i++)
                    begin
                        arc_cap[trail[i]] -= b;
                        arc_cap[trail[i] ^ 1] += b;
                    end
                    total += b;
                    depth = 0;
                    u = SOURCE_NODE;
                    continue;
                end
                a = cursor[u];
                while (a != 0 && (arc_cap[a] == 0 || level[arc_to[a]] != level[u] + 1))
                    a = arc_link[a];
                cursor[u] = a;
                if (a != 0 && depth <= NODES)
                begin
                    trail[depth++] = a;
                    u = arc_to[a];
                end
                else
                begin
                    level[u] = 0;
                    if (depth == 0) break;
                    depth--;
                    u = arc_to[trail[depth] ^ 1];
                end
            end
        endfunction

        function void note_edge(logic [NODE_W-1:0] t, logic [NODE_W-1:0] h,
                                logic [CAP_IN_W-1:0] c, logic l);
            int sink, ti, hi, ci;
            flow_word_t w;
            ti = int'(t);
            hi = int'(h);
            ci = int'(c);
            if (ti >= 1 && ti <= NODES && hi >= 1 && hi <= NODES)
            begin
                if (n_arcs + 2 < ARCS)
                begin
                    link(ti, hi, ci);
                    link(hi, ti, 0);
                end
                else
                begin
                    dropped = 1;
                end
            end
            if (!l) return;
            sink = (int'(node_cfg) > NODES) ? NODES : int'(node_cfg);
            if (sink > SOURCE_NODE)
                while (build_levels(sink)) push_blocking(sink);
            w.flow = total[FLOW_W-1:0];
            w.ovf = dropped;
            expected_q.push_back(w);
            clear_graph();
        endfunction

        function void check_result(logic [FLOW_W-1:0] flow, logic ovf);
            flow_word_t w;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result word flow %0d overflow %0d",
                         $realtime, flow, ovf);
                fails++;
                return;
            end
            w = expected_q.pop_front();
            if (flow !== w.flow)
            begin
                $display("%0t: max_flow expected %0d actual %0d", $realtime, w.flow, flow);
                fails++;
            end
            if (ovf !== w.ovf)
            begin
                $display("%0t: edge_overflow expected %0d actual %0d",
                         $realtime, w.ovf, ovf);
                fails++;
            end
        endfunction
    endclass

    logic                clk = 0;
    logic                rst_n = 0;
    logic                cfg_we = 0;
    logic [NODE_W-1:0]   cfg_wdata = 0;
    logic                in_valid = 0;
    logic                in_stall;
    logic [NODE_W-1:0]   tail_node = 1;
    logic [NODE_W-1:0]   head_node = 1;
    logic [CAP_IN_W-1:0] edge_capacity = 0;
    logic                last_edge = 0;
    logic                out_valid;
    logic                out_stall = 0;
    logic [FLOW_W-1:0]   max_flow;
    logic                edge_overflow;

    flow_scoreboard sb = new();
    int burst_left = 0;
    int sent = 0;
    int quiet_cycles = 0;
    logic [NODE_W-1:0] pool[6];
    logic [NODE_W-1:0] settings[10] = '{2, 5, 256, 12, 0, 511, 8, 1, 300, 40};

    dinic_max_flow_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .tail_node(tail_node), .head_node(head_node),
        .edge_capacity(edge_capacity), .last_edge(last_edge),
        .out_valid(out_valid), .out_stall(out_stall),
        .max_flow(max_flow), .edge_overflow(edge_overflow)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_edge(tail_node, head_node, edge_capacity, last_edge);
            if (out_valid && !out_stall)
                sb.check_result(max_flow, edge_overflow);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= DOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $realtime);
                $display("dinic_max_flow_unit verification failed");
                $finish;
            end
        end
    end

    // receiver: runs of no stall, light stall and heavy stall
    initial
    begin
        int run, pct;
        forever
        begin
            run = $urandom_range(5, 60);
            case ($urandom_range(0, 2))
                0: pct = 0;
                1: pct = 30;
                default: pct = 85;
            endcase
            repeat (run)
            begin
                @(negedge clk);
                out_stall = ($urandom_range(0, 99) < pct);
            end
        end
    end

    task automatic send_edge(logic [NODE_W-1:0] t, logic [NODE_W-1:0] h,
                             logic [CAP_IN_W-1:0] c, logic l);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        tail_node = t;
        head_node = h;
        edge_capacity = c;
        last_edge = l;
        in_valid = 1;
        do @(posedge clk); while (in_stall);
        burst_left--;
        sent++;
    endtask

    // drain all results, let the clearing pass finish
    task automatic settle();
        @(negedge clk);
        in_valid = 0;
        burst_left = 0;
        while (sb.expected_q.size() != 0) @(negedge clk);
        repeat (IDLE_WAIT) @(negedge clk);
    endtask

    task automatic set_nodes(logic [NODE_W-1:0] n);
        settle();
        cfg_wdata = n;
        cfg_we = 1;
        @(negedge clk);
        cfg_we = 0;
        sb.node_cfg = n;
    endtask

    function automatic logic [NODE_W-1:0] pick_node();
        case ($urandom_range(0, 19))
            0: return NODE_W'(($urandom_range(0, 1)) ? 0 : $urandom_range(NODES + 1, 511));
            1: return NODE_W'($urandom_range(1, NODES));
            default: return pool[$urandom_range(0, 5)];
        endcase
    endfunction

    function automatic logic [CAP_IN_W-1:0] pick_cap();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 16'hffff;
            2: return CAP_IN_W'($urandom_range(1, 20));
            default: return CAP_IN_W'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    task automatic random_cases(int items);
        int sink, n, stop;
        stop = sent + items;
        sink = (int'(sb.node_cfg) > NODES) ? NODES : int'(sb.node_cfg);
        while (sent < stop)
        begin
            pool[0] = NODE_W'(SOURCE_NODE);
            pool[1] = NODE_W'((sink >= 2) ? sink : $urandom_range(2, NODES));
            for (int i = 2; i < 6; i++)
                pool[i] = NODE_W'(($urandom_range(0, 1)) ? $urandom_range(1, NODES)
                                                         : $urandom_range(1, 12));
            n = $urandom_range(1, 14);
            for (int i = 0; i < n; i++)
                send_edge(pick_node(), pick_node(), pick_cap(), i == n - 1);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: default sink is node 2
        send_edge(1, 2, 16'hffff, 1);
        send_edge(1, 2, 0, 1);
        send_edge(1, 1, 100, 0);
        send_edge(2, 1, 50, 0);
        send_edge(1, 2, 7, 0);
        send_edge(1, 2, 9, 1);
        send_edge(0, 2, 5, 0);
        send_edge(1, 511, 5, 0);
        send_edge(1, 257, 5, 1);
        send_edge(1, 256, 40, 0);
        send_edge(256, 2, 30, 1);
        set_nodes(4);
        send_edge(1, 2, 10, 0);
        send_edge(1, 3, 10, 0);
        send_edge(2, 3, 1, 0);
        send_edge(2, 4, 8, 0);
        send_edge(3, 4, 10, 0);
        send_edge(4, 1, 3, 1);
        // edge table overflow: last edge itself dropped
        for (int i = 0; i < DEF_MAX_EDGES + 3; i++)
            send_edge(1, NODE_W'(2 + (i % 3)), 16'hffff, i == DEF_MAX_EDGES + 2);
        send_edge(1, 4, 1, 1);
        set_nodes(0);
        send_edge(1, 2, 5, 1);

        foreach (settings[k])
        begin
            set_nodes(settings[k]);
            random_cases(6);
        end

        settle();
        if (sb.fails == 0)
            $display("dinic_max_flow_unit verification clean");
        else
            $display("dinic_max_flow_unit verification failed");
        $finish;
    end
endmodule
